@@ src/dh_forward_kinematics_core_defines.svh @@
// Assertion macros used by the core file to check this block.
`ifndef DH_FORWARD_KINEMATICS_CORE_DEFINES_SVH
`define DH_FORWARD_KINEMATICS_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DHFK_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DHFK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dhfk_pkg.sv @@
`timescale 1ns / 1ps
package dhfk_pkg;

  localparam int DHFK_NUM_LINKS      = 8;
  localparam int DHFK_TRIG_FRAC_BITS = 14;

  localparam int IDX_W     = 3;
  localparam int FIELD_W   = 16;
  localparam int POS_OUT_W = 20;
  localparam int POS_W     = 26;

  localparam int FULL_TURN    = 23040;
  localparam int QUARTER_TURN = 5760;
  localparam int ANG_W        = 18;
  localparam int RED_W        = 15;
  localparam int QR_W         = 13;

  localparam logic [18:0] RAD_PER_UNIT_Q30 = 19'd292818;
  localparam logic [30:0] ONE_Q30          = 31'h4000_0000;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 33;
  localparam int MUL_P_W = 65;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic signed [POS_W-1:0] POS_SAT_HI = POS_W'((1 << (POS_OUT_W - 1)) - 1);
  localparam logic signed [POS_W-1:0] POS_SAT_LO = POS_W'(-(1 << (POS_OUT_W - 1)));

  typedef struct packed {
    logic signed [FIELD_W-1:0] length_a;
    logic signed [FIELD_W-1:0] twist_alpha;
    logic signed [FIELD_W-1:0] offset_d;
    logic signed [FIELD_W-1:0] angle_theta;
  } link_t;

  typedef struct packed {
    logic start;
    logic want_cos;
  } sin_req_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_req_t;

  // Reciprocals for exact division of a 32-bit value by 110, 72, 42, 20 and 6.
  function automatic logic [MUL_B_W-1:0] recip_mult(input logic [2:0] idx);
    logic [MUL_B_W-1:0] m;
    case (idx)
      3'd0:    m = 33'd4997780127;
      3'd1:    m = 33'd7635497416;
      3'd2:    m = 33'd6544712071;
      3'd3:    m = 33'd6871947674;
      3'd4:    m = 33'd5726623062;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [5:0] recip_shift(input logic [2:0] idx);
    logic [5:0] s;
    case (idx)
      3'd0:    s = 6'd39;
      3'd1:    s = 6'd39;
      3'd2:    s = 6'd38;
      3'd3:    s = 6'd37;
      3'd4:    s = 6'd35;
      default: s = 6'd39;
    endcase
    return s;
  endfunction

endpackage

@@ src/dhfk_in_if.sv @@
`timescale 1ns / 1ps
interface dhfk_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [2:0]         link_index;
  logic signed [15:0] length_a;
  logic signed [15:0] twist_alpha;
  logic signed [15:0] offset_d;
  logic signed [15:0] angle_theta;
  logic [2:0]         first_frame;
  logic [2:0]         last_joint;

  modport source (
    output valid, opcode, link_index, length_a, twist_alpha, offset_d, angle_theta,
    output first_frame, last_joint,
    input  ready
  );
  modport sink (
    input  valid, opcode, link_index, length_a, twist_alpha, offset_d, angle_theta,
    input  first_frame, last_joint,
    output ready
  );
endinterface

@@ src/dhfk_out_if.sv @@
`timescale 1ns / 1ps
interface dhfk_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] pos_x;
  logic signed [19:0] pos_y;
  logic signed [19:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

@@ src/dhfk_link_mem.sv @@
`timescale 1ns / 1ps
module dhfk_link_mem import dhfk_pkg::*; #(
  parameter int NUM_LINKS = DHFK_NUM_LINKS,
  parameter int IDXW      = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [IDXW-1:0] wr_addr_i,
  input  link_t           wr_data_i,
  input  logic            rd_en_i,
  input  logic [IDXW-1:0] rd_addr_i,
  output link_t           rd_data_o
);

  link_t                mem_q [NUM_LINKS];
  logic [NUM_LINKS-1:0] vld_q;
  link_t                rd_data_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // An entry never written reads as the cleared value.
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

@@ src/dhfk_sine_unit.sv @@
`timescale 1ns / 1ps
module dhfk_sine_unit import dhfk_pkg::*; #(
  parameter int TRIG_FRAC_BITS = DHFK_TRIG_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  sin_req_t                         req_i,
  input  logic signed [FIELD_W-1:0]        angle_i,
  output logic                             done_o,
  output logic signed [TRIG_FRAC_BITS+2:0] value_o
);

  localparam int TW  = TRIG_FRAC_BITS + 3;
  localparam int MW  = TRIG_FRAC_BITS + 2;
  localparam int RSH = 30 - TRIG_FRAC_BITS;
  localparam logic [3:0] PH_LAST_MUL = 4'd11;
  localparam logic [3:0] PH_RESULT   = 4'd12;
  localparam logic signed [ANG_W-1:0] FULL_S    = ANG_W'(FULL_TURN);
  localparam logic signed [ANG_W-1:0] QUARTER_S = ANG_W'(QUARTER_TURN);
  localparam logic [RED_W-1:0] Q1 = RED_W'(QUARTER_TURN);
  localparam logic [RED_W-1:0] Q2 = RED_W'(2 * QUARTER_TURN);
  localparam logic [RED_W-1:0] Q3 = RED_W'(3 * QUARTER_TURN);
  localparam logic [MW-1:0] MAG_LIM = MW'(1) << TRIG_FRAC_BITS;

  logic signed [ANG_W-1:0] u;
  logic [RED_W-1:0]        red;
  logic [RED_W-1:0]        rem_w;
  logic [1:0]              quad;
  logic [QR_W-1:0]         rem;
  logic [QR_W-1:0]         rr_d;

  logic                    busy_q;
  logic [3:0]              ph_q;
  logic [QR_W-1:0]         rr_q;
  logic                    neg_q;
  logic [30:0]             x_q;
  logic [31:0]             x2_q;
  logic [MUL_P_W-1:0]      prod_q;
  logic                    done_q;
  logic signed [TW-1:0]    value_q;

  logic [2:0]              j;
  logic [29:0]             q30;
  logic [30:0]             t_new;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [31:0]             s_rnd;
  logic [MW-1:0]           mag;

  always_comb begin
    u = ANG_W'(angle_i) + (req_i.want_cos ? QUARTER_S : '0);
    if (u < -FULL_S) begin
      red = RED_W'(u + (FULL_S <<< 1));
    end else if (u < 0) begin
      red = RED_W'(u + FULL_S);
    end else if (u >= FULL_S) begin
      red = RED_W'(u - FULL_S);
    end else begin
      red = RED_W'(u);
    end
    if (red >= Q3) begin
      quad  = 2'd3;
      rem_w = red - Q3;
    end else if (red >= Q2) begin
      quad  = 2'd2;
      rem_w = red - Q2;
    end else if (red >= Q1) begin
      quad  = 2'd1;
      rem_w = red - Q1;
    end else begin
      quad  = 2'd0;
      rem_w = red;
    end
    rem  = QR_W'(rem_w);
    rr_d = quad[0] ? (QR_W'(QUARTER_TURN) - rem) : rem;
  end

  always_comb begin
    j     = 3'(ph_q[3:1] - 3'd1);
    q30   = 30'(prod_q >> recip_shift(j));
    t_new = ONE_Q30 - {1'b0, q30};
    case (ph_q)
      4'd0: begin
        mul_a = MUL_A_W'(rr_q);
        mul_b = MUL_B_W'(RAD_PER_UNIT_Q30);
      end
      4'd1: begin
        mul_a = MUL_A_W'(prod_q[30:0]);
        mul_b = MUL_B_W'(prod_q[30:0]);
      end
      default: begin
        if (ph_q[0]) begin
          mul_a = (ph_q == PH_LAST_MUL) ? MUL_A_W'(x_q) : x2_q;
          mul_b = MUL_B_W'(t_new);
        end else begin
          mul_a = prod_q[61:30];
          mul_b = recip_mult(j);
        end
      end
    endcase
    s_rnd = {1'b0, prod_q[60:30]} + (32'd1 << (RSH - 1));
    mag   = s_rnd[RSH +: MW];
    if (mag > MAG_LIM) begin
      mag = MAG_LIM;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        ph_q   <= '0;
      end else if (busy_q) begin
        if (ph_q == PH_RESULT) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          ph_q <= ph_q + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rr_q  <= rr_d;
      neg_q <= quad[1];
    end
    if (busy_q) begin
      prod_q <= mul_a * mul_b;
      if (ph_q == 4'd1) begin
        x_q <= prod_q[30:0];
      end
      if (ph_q == 4'd2) begin
        x2_q <= prod_q[61:30];
      end
      if (ph_q == PH_RESULT) begin
        value_q <= neg_q ? -$signed(TW'(mag)) : $signed(TW'(mag));
      end
    end
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

@@ src/dhfk_chain_mac.sv @@
`timescale 1ns / 1ps
module dhfk_chain_mac import dhfk_pkg::*; #(
  parameter int TRIG_FRAC_BITS = DHFK_TRIG_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mac_req_t                         req_i,
  input  logic signed [TRIG_FRAC_BITS+2:0] ct_i,
  input  logic signed [TRIG_FRAC_BITS+2:0] st_i,
  input  logic signed [TRIG_FRAC_BITS+2:0] ca_i,
  input  logic signed [TRIG_FRAC_BITS+2:0] sa_i,
  input  logic signed [FIELD_W-1:0]        len_i,
  input  logic signed [FIELD_W-1:0]        off_i,
  output logic                             done_o,
  output logic signed [POS_W-1:0]          pos_x_o,
  output logic signed [POS_W-1:0]          pos_y_o,
  output logic signed [POS_W-1:0]          pos_z_o
);

  localparam int TW  = TRIG_FRAC_BITS + 3;
  localparam int OPW = (TW > FIELD_W + 2) ? TW : FIELD_W + 2;
  localparam int PRW = 2 * OPW;
  localparam int ACW = PRW + 2;
  localparam logic signed [TW-1:0] ONE = {2'b00, 1'b1, {TRIG_FRAC_BITS{1'b0}}};

  logic signed [TW-1:0]    rot_q [3][3];
  logic signed [TW-1:0]    tmp0_q, tmp1_q;
  logic signed [TW-1:0]    lr01_q, lr02_q, lr11_q, lr12_q;
  logic signed [OPW-1:0]   lp0_q, lp1_q;
  logic signed [POS_W-1:0] pos_q [3];

  logic       run_q, inl_q;
  logic [2:0] l_q;
  logic [1:0] r_q, g_q, k_q;

  logic              pv_q, pf_q, pl_q, pinl_q;
  logic [2:0]        pidx_q;
  logic [1:0]        pr_q, pg_q;
  logic signed [PRW-1:0] prod_q;
  logic signed [ACW-1:0] acc_q;
  logic              done_q;

  logic signed [OPW-1:0] op_a, op_b;
  logic signed [ACW-1:0] acc_sum, rnd;

  function automatic logic signed [ACW-1:0] round_frac(input logic signed [ACW-1:0] v);
    logic [ACW-1:0] mag;
    logic [ACW-1:0] half;
    half = ACW'(1) << (TRIG_FRAC_BITS - 1);
    mag  = v[ACW-1] ? -v : v;
    mag  = (mag + half) >> TRIG_FRAC_BITS;
    return v[ACW-1] ? -$signed(mag) : $signed(mag);
  endfunction

  always_comb begin
    if (inl_q) begin
      case (l_q)
        3'd0: begin op_a = OPW'(len_i); op_b = OPW'(ct_i); end
        3'd1: begin op_a = OPW'(len_i); op_b = OPW'(st_i); end
        3'd2: begin op_a = OPW'(st_i);  op_b = OPW'(ca_i); end
        3'd3: begin op_a = OPW'(st_i);  op_b = OPW'(sa_i); end
        3'd4: begin op_a = OPW'(ct_i);  op_b = OPW'(ca_i); end
        default: begin op_a = OPW'(ct_i); op_b = OPW'(sa_i); end
      endcase
    end else begin
      op_a = OPW'(rot_q[r_q][k_q]);
      case ({g_q, k_q})
        4'b00_00: op_b = lp0_q;
        4'b00_01: op_b = lp1_q;
        4'b00_10: op_b = OPW'(off_i);
        4'b01_00: op_b = OPW'(ct_i);
        4'b01_01: op_b = OPW'(st_i);
        4'b10_00: op_b = OPW'(lr01_q);
        4'b10_01: op_b = OPW'(lr11_q);
        4'b10_10: op_b = OPW'(sa_i);
        4'b11_00: op_b = OPW'(lr02_q);
        4'b11_01: op_b = OPW'(lr12_q);
        4'b11_10: op_b = OPW'(ca_i);
        default:  op_b = '0;
      endcase
    end
    acc_sum = (pf_q ? ACW'(0) : acc_q) + ACW'(prod_q);
    rnd     = round_frac(acc_sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      inl_q  <= 1'b0;
      l_q    <= '0;
      r_q    <= '0;
      g_q    <= '0;
      k_q    <= '0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pv_q   <= run_q;
      done_q <= pv_q && pl_q && !pinl_q && (pr_q == 2'd2) && (pg_q == 2'd3);
      if (req_i.start) begin
        run_q <= 1'b1;
        inl_q <= 1'b1;
        l_q   <= '0;
      end else if (run_q) begin
        if (inl_q) begin
          if (l_q == 3'd5) begin
            inl_q <= 1'b0;
            r_q   <= '0;
            g_q   <= '0;
            k_q   <= '0;
          end else begin
            l_q <= l_q + 3'd1;
          end
        end else if (k_q == 2'd2) begin
          k_q <= '0;
          if (g_q == 2'd3) begin
            g_q <= '0;
            if (r_q == 2'd2) begin
              run_q <= 1'b0;
            end else begin
              r_q <= r_q + 2'd1;
            end
          end else begin
            g_q <= g_q + 2'd1;
          end
        end else begin
          k_q <= k_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    pf_q   <= inl_q || (k_q == 2'd0);
    pl_q   <= inl_q || (k_q == 2'd2);
    pinl_q <= inl_q;
    pidx_q <= l_q;
    pr_q   <= r_q;
    pg_q   <= g_q;
    if (pv_q) begin
      acc_q <= acc_sum;
    end
    if (req_i.clear) begin
      for (int r = 0; r < 3; r++) begin
        pos_q[r] <= '0;
        for (int c = 0; c < 3; c++) begin
          rot_q[r][c] <= (r == c) ? ONE : '0;
        end
      end
    end else if (pv_q && pl_q) begin
      if (pinl_q) begin
        case (pidx_q)
          3'd0:    lp0_q  <= OPW'(rnd);
          3'd1:    lp1_q  <= OPW'(rnd);
          3'd2:    lr01_q <= -TW'(rnd);
          3'd3:    lr02_q <= TW'(rnd);
          3'd4:    lr11_q <= TW'(rnd);
          default: lr12_q <= -TW'(rnd);
        endcase
      end else begin
        case (pg_q)
          2'd0: pos_q[pr_q] <= pos_q[pr_q] + POS_W'(rnd);
          2'd1: tmp0_q <= TW'(rnd);
          2'd2: tmp1_q <= TW'(rnd);
          default: begin
            rot_q[pr_q][0] <= tmp0_q;
            rot_q[pr_q][1] <= tmp1_q;
            rot_q[pr_q][2] <= TW'(rnd);
          end
        endcase
      end
    end
  end

  assign done_o  = done_q;
  assign pos_x_o = pos_q[0];
  assign pos_y_o = pos_q[1];
  assign pos_z_o = pos_q[2];

endmodule

@@ src/dh_forward_kinematics_core.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Beat contents
// in_i     sink       opcode, link_index, length_a, twist_alpha, offset_d, angle_theta,
//                     first_frame, last_joint
// out_o    source     pos_x, pos_y, pos_z
//
// A write beat produces no output beat.
// A query, for each link of the chain that lies in the table, reads the link, runs the sine unit
// four times, the first run started in the load cycle, and then runs the multiply-accumulate
// phase; each unit owns one multiplier. A link beyond the table is skipped.
// Reset clears the link table through per-entry valid bits; no clearing pass is needed.
// Input beats are taken while a finished result waits; a new query stalls only at its end.
`include "dh_forward_kinematics_core_defines.svh"
module dh_forward_kinematics_core import dhfk_pkg::*; #(
  parameter int NUM_LINKS      = DHFK_NUM_LINKS,
  parameter int TRIG_FRAC_BITS = DHFK_TRIG_FRAC_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dhfk_in_if.sink    in_i,
  dhfk_out_if.source out_o
);

  localparam int IDXW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int TW   = TRIG_FRAC_BITS + 3;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_TRIG = 3'd3;
  localparam logic [2:0] ST_MAC  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] last_q;
  logic [1:0]       cnt_q, cnt_d;
  logic [1:0]       cnt_nxt;
  link_t            link_q;
  logic signed [TW-1:0] ct_q, st_q, ca_q, sa_q;

  logic                         out_valid_q;
  logic signed [POS_OUT_W-1:0]  pos_x_q, pos_y_q, pos_z_q;

  logic     in_acc;
  logic     out_load;
  logic     mem_wr, mem_rd;
  link_t    wr_link, rd_link;
  sin_req_t sin_req;
  logic signed [FIELD_W-1:0] sin_angle;
  logic     sin_done;
  logic signed [TW-1:0] sin_value;
  mac_req_t mac_req;
  logic     mac_done;
  logic signed [POS_W-1:0] mac_x, mac_y, mac_z;

  function automatic logic signed [POS_OUT_W-1:0] sat_pos(input logic signed [POS_W-1:0] v);
    logic signed [POS_OUT_W-1:0] r;
    if (v > POS_SAT_HI) begin
      r = POS_OUT_W'(POS_SAT_HI);
    end else if (v < POS_SAT_LO) begin
      r = POS_OUT_W'(POS_SAT_LO);
    end else begin
      r = POS_OUT_W'(v);
    end
    return r;
  endfunction

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign mem_wr     = in_acc && (in_i.opcode == OP_WRITE) && (int'(in_i.link_index) < NUM_LINKS);
  assign mem_rd     = (state_q == ST_READ) && (int'(cur_q) < NUM_LINKS);
  assign cnt_nxt    = cnt_q + 2'd1;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  assign wr_link.length_a    = in_i.length_a;
  assign wr_link.twist_alpha = in_i.twist_alpha;
  assign wr_link.offset_d    = in_i.offset_d;
  assign wr_link.angle_theta = in_i.angle_theta;

  always_comb begin
    sin_req.start    = (state_q == ST_LOAD) || ((state_q == ST_TRIG) && sin_done && (cnt_q != 2'd3));
    sin_req.want_cos = (state_q == ST_LOAD) ? 1'b1 : ~cnt_nxt[0];
    sin_angle        = (state_q == ST_LOAD) ? rd_link.angle_theta :
                       (cnt_nxt[1] ? link_q.twist_alpha : link_q.angle_theta);
    mac_req.start    = (state_q == ST_TRIG) && sin_done && (cnt_q == 2'd3);
    mac_req.clear    = in_acc && (in_i.opcode == OP_QUERY);
  end

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_i.opcode == OP_QUERY)) begin
          cur_d   = in_i.first_frame;
          state_d = (in_i.last_joint < in_i.first_frame) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        if (mem_rd) begin
          state_d = ST_LOAD;
        end else if (cur_q == last_q) begin
          state_d = ST_DONE;
        end else begin
          cur_d = cur_q + 3'd1;
        end
      end
      ST_LOAD: begin
        cnt_d   = '0;
        state_d = ST_TRIG;
      end
      ST_TRIG: begin
        if (sin_done) begin
          cnt_d = cnt_nxt;
          if (cnt_q == 2'd3) begin
            state_d = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          if (cur_q == last_q) begin
            state_d = ST_DONE;
          end else begin
            cur_d   = cur_q + 3'd1;
            state_d = ST_READ;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      last_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      cnt_q   <= cnt_d;
      if (in_acc && (in_i.opcode == OP_QUERY)) begin
        last_q <= in_i.last_joint;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      link_q <= rd_link;
    end
    if ((state_q == ST_TRIG) && sin_done) begin
      case (cnt_q)
        2'd0:    ct_q <= sin_value;
        2'd1:    st_q <= sin_value;
        2'd2:    ca_q <= sin_value;
        default: sa_q <= sin_value;
      endcase
    end
    if (out_load) begin
      pos_x_q <= sat_pos(mac_x);
      pos_y_q <= sat_pos(mac_y);
      pos_z_q <= sat_pos(mac_z);
    end
  end

  dhfk_link_mem #(
    .NUM_LINKS (NUM_LINKS),
    .IDXW      (IDXW)
  ) u_link_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mem_wr),
    .wr_addr_i (IDXW'(in_i.link_index)),
    .wr_data_i (wr_link),
    .rd_en_i   (mem_rd),
    .rd_addr_i (IDXW'(cur_q)),
    .rd_data_o (rd_link)
  );

  dhfk_sine_unit #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_sine_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sin_req),
    .angle_i (sin_angle),
    .done_o  (sin_done),
    .value_o (sin_value)
  );

  dhfk_chain_mac #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_chain_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mac_req),
    .ct_i    (ct_q),
    .st_i    (st_q),
    .ca_i    (ca_q),
    .sa_i    (sa_q),
    .len_i   (link_q.length_a),
    .off_i   (link_q.offset_d),
    .done_o  (mac_done),
    .pos_x_o (mac_x),
    .pos_y_o (mac_y),
    .pos_z_o (mac_z)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.pos_x = pos_x_q;
  assign out_o.pos_y = pos_y_q;
  assign out_o.pos_z = pos_z_q;

  `DHFK_ASSERT_IMPLIES(a_sin_in_trig, clk_i, rst_ni, sin_done, state_q == ST_TRIG, "sine result outside the trig phase")
  `DHFK_ASSERT_IMPLIES(a_mac_in_mac, clk_i, rst_ni, mac_done, state_q == ST_MAC, "chain update finished outside the chain phase")
  `DHFK_ASSERT_IMPLIES(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_DONE, "output beat raised without a finished query")
  `DHFK_ASSERT_NEXT(a_reversed_chain, clk_i, rst_ni, in_acc && (in_i.opcode == OP_QUERY) && (in_i.last_joint < in_i.first_frame), state_q == ST_DONE, "reversed chain did not finish at once")

endmodule

@@ bench/dh_forward_kinematics_core_checker.sv @@
`timescale 1ns / 1ps
module dh_forward_kinematics_core_checker import dhfk_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dhfk_in_if.sink    in_mon,
  dhfk_out_if.sink   out_mon,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
  } position_t;

  link_t     arm_table [DHFK_NUM_LINKS];
  position_t expected_positions[$];

  function automatic longint round_frac(longint v);
    longint half;
    half = longint'(1) << (DHFK_TRIG_FRAC_BITS - 1);
    if (v >= 0) return (v + half) >>> DHFK_TRIG_FRAC_BITS;
    return -(((-v) + half) >>> DHFK_TRIG_FRAC_BITS);
  endfunction

  function automatic longint quadrant_sine(longint r);
    longint unsigned x, x2, t, s, v, one;
    one = longint'(1) << 30;
    x = r * 292818;
    x2 = (x * x) >> 30;
    t = one - x2 / 110;
    t = one - ((x2 * t) >> 30) / 72;
    t = one - ((x2 * t) >> 30) / 42;
    t = one - ((x2 * t) >> 30) / 20;
    t = one - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    v = (s + (longint'(1) << (29 - DHFK_TRIG_FRAC_BITS))) >> (30 - DHFK_TRIG_FRAC_BITS);
    if (v > (longint'(1) << DHFK_TRIG_FRAC_BITS)) v = longint'(1) << DHFK_TRIG_FRAC_BITS;
    return longint'(v);
  endfunction

  function automatic longint sine_of(int ang);
    int a, q, r;
    longint mag;
    a = ang % FULL_TURN;
    if (a < 0) a += FULL_TURN;
    q = a / QUARTER_TURN;
    r = a % QUARTER_TURN;
    mag = (q % 2 == 1) ? quadrant_sine(QUARTER_TURN - r) : quadrant_sine(r);
    return (q >= 2) ? -mag : mag;
  endfunction

  function automatic logic signed [19:0] clamp_pos(longint v);
    if (v > 524287) v = 524287;
    if (v < -524288) v = -524288;
    return v[19:0];
  endfunction

  function automatic position_t chain_position(int first, int last);
    longint rot[3][3], nrot[3][3], lr[3][3], lp[3], pos[3], acc;
    longint ct, st, ca, sa, a;
    position_t p;
    for (int r = 0; r < 3; r++) begin
      pos[r] = 0;
      for (int c = 0; c < 3; c++) rot[r][c] = (r == c) ? (longint'(1) << DHFK_TRIG_FRAC_BITS) : 0;
    end
    for (int i = first; i <= last; i++) begin
      if (i >= DHFK_NUM_LINKS) continue;
      ct = sine_of(int'(arm_table[i].angle_theta) + QUARTER_TURN);
      st = sine_of(int'(arm_table[i].angle_theta));
      ca = sine_of(int'(arm_table[i].twist_alpha) + QUARTER_TURN);
      sa = sine_of(int'(arm_table[i].twist_alpha));
      a = arm_table[i].length_a;
      lr[0][0] = ct; lr[0][1] = -round_frac(st * ca); lr[0][2] = round_frac(st * sa);
      lr[1][0] = st; lr[1][1] = round_frac(ct * ca);  lr[1][2] = -round_frac(ct * sa);
      lr[2][0] = 0;  lr[2][1] = sa;                   lr[2][2] = ca;
      lp[0] = round_frac(a * ct);
      lp[1] = round_frac(a * st);
      lp[2] = arm_table[i].offset_d;
      for (int r = 0; r < 3; r++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rot[r][k] * lp[k];
        pos[r] += round_frac(acc);
        for (int c = 0; c < 3; c++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += rot[r][k] * lr[k][c];
          nrot[r][c] = round_frac(acc);
        end
      end
      rot = nrot;
    end
    p.x = clamp_pos(pos[0]);
    p.y = clamp_pos(pos[1]);
    p.z = clamp_pos(pos[2]);
    return p;
  endfunction

  assign pending_o = expected_positions.size();

  always @(posedge clk_i or negedge rst_ni) begin
    position_t want;
    int errs;
    if (!rst_ni) begin
      fail_count_o <= 0;
      for (int i = 0; i < DHFK_NUM_LINKS; i++) arm_table[i] = '0;
      expected_positions.delete();
    end else begin
      errs = 0;
      if (out_mon.valid && out_mon.ready) begin
        if (expected_positions.size() == 0) begin
          $error("Output beat with no query pending");
          errs++;
        end else begin
          want = expected_positions.pop_front();
          if (out_mon.pos_x !== want.x) begin
            $error("pos_x expected %0d got %0d", want.x, out_mon.pos_x);
            errs++;
          end
          if (out_mon.pos_y !== want.y) begin
            $error("pos_y expected %0d got %0d", want.y, out_mon.pos_y);
            errs++;
          end
          if (out_mon.pos_z !== want.z) begin
            $error("pos_z expected %0d got %0d", want.z, out_mon.pos_z);
            errs++;
          end
        end
      end
      if (errs != 0) begin
        fail_count_o <= fail_count_o + errs;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.opcode == OP_WRITE) begin
          if (in_mon.link_index < DHFK_NUM_LINKS)
            arm_table[in_mon.link_index] = '{in_mon.length_a, in_mon.twist_alpha,
                                             in_mon.offset_d, in_mon.angle_theta};
        end else if (in_mon.last_joint < in_mon.first_frame) begin
          expected_positions.push_back('{20'sd0, 20'sd0, 20'sd0});
        end else begin
          expected_positions.push_back(chain_position(in_mon.first_frame, in_mon.last_joint));
        end
      end
    end
  end

endmodule

@@ bench/dh_forward_kinematics_core_test.sv @@
`timescale 1ns / 1ps
module dh_forward_kinematics_core_test import dhfk_pkg::*;;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  bit   sink_may_stall;

  dhfk_in_if  in_ch ();
  dhfk_out_if out_ch ();

  dh_forward_kinematics_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  dh_forward_kinematics_core_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("FAILURE");
    $finish;
  end

  // After every beat, when sink_may_stall is set, the receiver picks a fresh random wait with ready low.
  initial begin
    int wait_cycles;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      wait_cycles = sink_may_stall ? $urandom_range(0, 3) : 0;
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
    end
  end

  task automatic send_beat(logic op, logic [2:0] idx, logic signed [15:0] len,
                           logic signed [15:0] twist, logic signed [15:0] offs,
                           logic signed [15:0] theta, logic [2:0] first,
                           logic [2:0] last, bit may_idle);
    int gap;
    gap = may_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.link_index  <= idx;
    in_ch.length_a    <= len;
    in_ch.twist_alpha <= twist;
    in_ch.offset_d    <= offs;
    in_ch.angle_theta <= theta;
    in_ch.first_frame <= first;
    in_ch.last_joint  <= last;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic write_link(logic [2:0] idx, logic signed [15:0] len,
                            logic signed [15:0] twist, logic signed [15:0] offs,
                            logic signed [15:0] theta, bit may_idle);
    send_beat(OP_WRITE, idx, len, twist, offs, theta, 3'($urandom), 3'($urandom), may_idle);
  endtask

  task automatic query_chain(logic [2:0] first, logic [2:0] last, bit may_idle);
    send_beat(OP_QUERY, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), first, last, may_idle);
  endtask

  function automatic logic signed [15:0] random_angle();
    case ($urandom_range(0, 3))
      0:       return 16'($signed($urandom_range(0, 46080)) - 23040);
      1:       return 16'($urandom);
      2:       return 16'(QUARTER_TURN * $signed($urandom_range(0, 8)) - FULL_TURN);
      default: return 16'($signed($urandom_range(0, 11520)) - 5760);
    endcase
  endfunction

  initial begin
    bit idle_on;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_WRITE;
    in_ch.link_index  = '0;
    in_ch.length_a    = '0;
    in_ch.twist_alpha = '0;
    in_ch.offset_d    = '0;
    in_ch.angle_theta = '0;
    in_ch.first_frame = '0;
    in_ch.last_joint  = '0;
    sink_may_stall    = 1'b0;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    query_chain(3'd0, 3'd7, 1'b0);
    write_link(3'd0, 16'sh7fff, 16'sd0, 16'sh7fff, 16'sd0, 1'b0);
    write_link(3'd1, -16'sd32768, 16'sd23040, -16'sd32768, -16'sd23040, 1'b0);
    write_link(3'd2, 16'sd256, 16'sd5760, 16'sd256, 16'sd32767, 1'b0);
    write_link(3'd3, 16'sh7fff, -16'sd5760, 16'sh7fff, -16'sd32768, 1'b0);
    write_link(3'd4, 16'sh7fff, 16'sd11520, 16'sh7fff, 16'sd17280, 1'b0);
    write_link(3'd5, 16'sh7fff, 16'sd0, 16'sh7fff, 16'sd0, 1'b0);
    write_link(3'd6, 16'sh7fff, 16'sd0, 16'sh7fff, 16'sd0, 1'b0);
    write_link(3'd7, 16'sh7fff, 16'sd0, 16'sh7fff, 16'sd0, 1'b0);
    query_chain(3'd0, 3'd0, 1'b0);
    query_chain(3'd1, 3'd1, 1'b0);
    query_chain(3'd2, 3'd3, 1'b0);
    query_chain(3'd0, 3'd7, 1'b0);
    query_chain(3'd5, 3'd2, 1'b0);
    query_chain(3'd7, 3'd0, 1'b0);
    write_link(3'd5, -16'sd32768, 16'sd0, -16'sd32768, 16'sd0, 1'b0);
    write_link(3'd6, -16'sd32768, 16'sd0, -16'sd32768, 16'sd0, 1'b0);
    write_link(3'd7, -16'sd32768, 16'sd0, -16'sd32768, 16'sd0, 1'b0);
    query_chain(3'd4, 3'd7, 1'b0);
    query_chain(3'd7, 3'd7, 1'b0);

    // Hold off until every pending position has been returned.
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);

    sink_may_stall = 1'b1;
    for (int n = 0; n < 1000; n++) begin
      idle_on = (n / 100) % 3 != 2;
      sink_may_stall = idle_on;
      if ($urandom_range(0, 2) != 0) begin
        write_link(3'($urandom), ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                   16'($signed($urandom_range(0, 2048)) - 1024),
                   random_angle(), 16'($urandom), random_angle(), idle_on);
      end else begin
        automatic logic [2:0] f = 3'($urandom_range(0, 7));
        automatic logic [2:0] l = ($urandom_range(0, 7) == 0) ? 3'($urandom) :
                                  3'($urandom_range(f, f + 2 > 7 ? 7 : f + 2));
        query_chain(f, l, idle_on);
      end
    end
    in_ch.valid <= 1'b0;
    @(posedge clk_i);

    fork
      while (pending != 0) @(posedge clk_i);
      begin
        repeat (2000000) @(posedge clk_i);
      end
    join_any
    disable fork;
    repeat (1000) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
